// ===== rtl/m3h_pkg.sv =====
// shared types, constants and helper functions for the murmur3 low-64 hash block
`timescale 1ns / 1ps
`default_nettype none

package m3h_pkg;

  // width of the running byte counter, saturates at all ones
  localparam int unsigned LENGTH_BITS = 32;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // hash constants
  localparam logic [63:0] MUL_A   = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MUL_B   = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] ADD_ONE = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] ADD_TWO = 64'h0000_0000_3849_5ab5;
  localparam logic [63:0] FIN_A   = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_B   = 64'hc4ce_b9fe_1a85_ec53;

  // block queue between front and back, depth is a power of two
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // one classified block as handed from front to back
  typedef struct packed {
    logic [63:0] k1;       // masked low word
    logic [63:0] k2;       // masked high word
    logic [31:0] seed;     // raw signed seed
    logic [4:0]  cnt;      // effective byte count, 0..16
    logic        do_k1;    // low word takes part
    logic        do_k2;    // high word takes part
    logic        full;     // full body round
    logic        first;    // first block of a message
    logic        last;     // last block of a message
    logic        nul;      // null flag
  } blk_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    rotl64 = (v << r) | (v >> (64 - r));
  endfunction

  // ones in the lowest n bytes, n in 0..8
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    byte_mask = m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/m3h_fifo.sv =====
// short block queue between the front classifier and the back engine
`timescale 1ns / 1ps
`default_nettype none

module m3h_fifo import m3h_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  blk_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output blk_entry_t entry_o
);

  blk_entry_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]      count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m3h_front.sv =====
// front classifier: takes items, masks tail bytes, marks first and last blocks
`timescale 1ns / 1ps
`default_nettype none

module m3h_front import m3h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_low_i,
  input  logic [63:0] data_high_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_block_i,
  input  logic [31:0] seed_i,
  input  logic        is_null_i,
  input  logic        q_full_i,
  output logic        push_o,
  output blk_entry_t  entry_o
);

  logic       mid_q;
  logic [4:0] cnt_eff;
  logic       full;
  logic       tail_hi;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // non-last blocks and oversize counts are full blocks
  assign cnt_eff = (!last_block_i || (byte_count_i > 5'd16)) ? 5'd16 : byte_count_i;
  assign full    = (cnt_eff == 5'd16);
  assign tail_hi = (cnt_eff > 5'd8);

  always_comb begin
    entry_o.seed  = seed_i;
    entry_o.cnt   = cnt_eff;
    entry_o.do_k1 = (cnt_eff != 5'd0);
    entry_o.do_k2 = tail_hi;
    entry_o.full  = full;
    entry_o.first = !mid_q;
    entry_o.last  = last_block_i;
    entry_o.nul   = is_null_i;
    if (full) begin
      entry_o.k1 = data_low_i;
      entry_o.k2 = data_high_i;
    end else begin
      entry_o.k1 = tail_hi ? data_low_i : (data_low_i & byte_mask(cnt_eff[3:0]));
      entry_o.k2 = tail_hi ? (data_high_i & byte_mask(4'(cnt_eff - 5'd8))) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (push_o) begin
      mid_q <= !last_block_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m3h_mul.sv =====
// 64x64 multiplier, low 64 bits, over three passes of one 32x32 multiplier
`timescale 1ns / 1ps
`default_nettype none

module m3h_mul import m3h_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LL   = 2'd1;
  localparam logic [1:0] PH_LH   = 2'd2;
  localparam logic [1:0] PH_HL   = 2'd3;

  logic [1:0]  phase_q;
  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic        done_q;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    case (phase_q)
      PH_LH: begin
        ma = a_q[31:0];
        mb = b_q[63:32];
      end
      PH_HL: begin
        ma = a_q[63:32];
        mb = b_q[31:0];
      end
      default: begin
        ma = a_q[31:0];
        mb = b_q[31:0];
      end
    endcase
    prod  = 64'(ma) * 64'(mb);
    // cross terms only touch the upper half
    acc_d = (phase_q == PH_LL) ? prod : (acc_q + {prod[31:0], 32'd0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (phase_q == PH_HL);
      case (phase_q)
        PH_IDLE: if (req_i.start) phase_q <= PH_LL;
        PH_LL:   phase_q <= PH_LH;
        PH_LH:   phase_q <= PH_HL;
        PH_HL:   phase_q <= PH_IDLE;
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    if (phase_q != PH_IDLE) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

`default_nettype wire

// ===== rtl/m3h_back.sv =====
// back engine: lane rounds, tail mixing, finalization and result register
`timescale 1ns / 1ps
`default_nettype none

module m3h_back import m3h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  blk_entry_t  q_entry_i,
  output logic        q_pop_o,
  output mul_req_t    mul_req_o,
  input  mul_rsp_t    mul_rsp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_K1A  = 4'd1;
  localparam logic [3:0] S_K1B  = 4'd2;
  localparam logic [3:0] S_K2A  = 4'd3;
  localparam logic [3:0] S_K2B  = 4'd4;
  localparam logic [3:0] S_MIX1 = 4'd5;
  localparam logic [3:0] S_MIX2 = 4'd6;
  localparam logic [3:0] S_TAIL = 4'd7;
  localparam logic [3:0] S_FIN0 = 4'd8;
  localparam logic [3:0] S_FIN1 = 4'd9;
  localparam logic [3:0] S_F1A  = 4'd10;
  localparam logic [3:0] S_F1B  = 4'd11;
  localparam logic [3:0] S_F2A  = 4'd12;
  localparam logic [3:0] S_F2B  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]             state_q, state_d;
  logic                   issued_q, issued_d;
  logic [63:0]            lane1_q, lane1_d, lane2_q, lane2_d;
  logic [LENGTH_BITS-1:0] total_q, total_d;
  logic                   null_q, null_d;
  logic [63:0]            k1_q, k1_d, k2_q, k2_d;
  logic [63:0]            t1_q, t1_d, t2_q, t2_d;
  logic                   do_k2_q, do_k2_d, full_q, full_d, last_q, last_d;
  logic                   out_valid_q, out_valid_d;
  logic [63:0]            out_q, out_d;

  logic [63:0]            seed_ext, len64, x1, x2, s2, mix;
  logic [LENGTH_BITS-1:0] base, room;
  logic [3:0]             after_blk;

  assign seed_ext  = {{32{q_entry_i.seed[31]}}, q_entry_i.seed};
  assign len64     = 64'(total_q);
  assign after_blk = last_q ? S_FIN0 : S_IDLE;
  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;

  // multiplier operands by step
  always_comb begin
    mul_req_o.start = 1'b0;
    mul_req_o.a     = k1_q;
    mul_req_o.b     = MUL_A;
    case (state_q)
      S_K1A: begin mul_req_o.a = k1_q; mul_req_o.b = MUL_A; mul_req_o.start = !issued_q; end
      S_K1B: begin mul_req_o.a = k1_q; mul_req_o.b = MUL_B; mul_req_o.start = !issued_q; end
      S_K2A: begin mul_req_o.a = k2_q; mul_req_o.b = MUL_B; mul_req_o.start = !issued_q; end
      S_K2B: begin mul_req_o.a = k2_q; mul_req_o.b = MUL_A; mul_req_o.start = !issued_q; end
      S_F1A: begin mul_req_o.a = t1_q; mul_req_o.b = FIN_A; mul_req_o.start = !issued_q; end
      S_F1B: begin mul_req_o.a = t1_q; mul_req_o.b = FIN_B; mul_req_o.start = !issued_q; end
      S_F2A: begin mul_req_o.a = t2_q; mul_req_o.b = FIN_A; mul_req_o.start = !issued_q; end
      S_F2B: begin mul_req_o.a = t2_q; mul_req_o.b = FIN_B; mul_req_o.start = !issued_q; end
      default: mul_req_o.start = 1'b0;
    endcase
  end

  assign mix = mul_rsp_i.p ^ (mul_rsp_i.p >> 33);

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    lane1_d     = lane1_q;
    lane2_d     = lane2_q;
    total_d     = total_q;
    null_d      = null_q;
    k1_d        = k1_q;
    k2_d        = k2_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    do_k2_d     = do_k2_q;
    full_d      = full_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    base        = q_entry_i.first ? '0 : total_q;
    room        = LEN_MAX - base;
    x1          = '0;
    x2          = '0;
    s2          = '0;

    if ((mul_req_o.start)) begin
      issued_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          // first block reloads lanes from the seed
          lane1_d = q_entry_i.first ? seed_ext : lane1_q;
          lane2_d = q_entry_i.first ? seed_ext : lane2_q;
          null_d  = (q_entry_i.first ? 1'b0 : null_q) || q_entry_i.nul;
          total_d = (LENGTH_BITS'(q_entry_i.cnt) > room) ? LEN_MAX
                                                         : base + LENGTH_BITS'(q_entry_i.cnt);
          k1_d    = q_entry_i.k1;
          k2_d    = q_entry_i.k2;
          do_k2_d = q_entry_i.do_k2;
          full_d  = q_entry_i.full;
          last_d  = q_entry_i.last;
          state_d = q_entry_i.do_k1 ? S_K1A : (q_entry_i.last ? S_FIN0 : S_IDLE);
        end
      end
      S_K1A: begin
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          k1_d     = rotl64(mul_rsp_i.p, 31);
          state_d  = S_K1B;
        end
      end
      S_K1B: begin
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          k1_d     = mul_rsp_i.p;
          state_d  = do_k2_q ? S_K2A : (full_q ? S_MIX1 : S_TAIL);
        end
      end
      S_K2A: begin
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          k2_d     = rotl64(mul_rsp_i.p, 33);
          state_d  = S_K2B;
        end
      end
      S_K2B: begin
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          k2_d     = mul_rsp_i.p;
          state_d  = full_q ? S_MIX1 : S_TAIL;
        end
      end
      S_MIX1: begin
        x1      = rotl64(lane1_q ^ k1_q, 27) + lane2_q;
        lane1_d = (x1 << 2) + x1 + ADD_ONE;
        state_d = S_MIX2;
      end
      S_MIX2: begin
        x2      = rotl64(lane2_q ^ k2_q, 31) + lane1_q;
        lane2_d = (x2 << 2) + x2 + ADD_TWO;
        state_d = after_blk;
      end
      S_TAIL: begin
        // k1 always takes part here, k2 only past eight bytes
        lane1_d = lane1_q ^ k1_q;
        lane2_d = do_k2_q ? (lane2_q ^ k2_q) : lane2_q;
        state_d = after_blk;
      end
      S_FIN0: begin
        t1_d    = (lane1_q ^ len64) + (lane2_q ^ len64);
        t2_d    = lane2_q ^ len64;
        state_d = S_FIN1;
      end
      S_FIN1: begin
        s2      = t2_q + t1_q;
        t2_d    = s2 ^ (s2 >> 33);
        t1_d    = t1_q ^ (t1_q >> 33);
        state_d = S_F1A;
      end
      S_F1A: begin
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          t1_d     = mix;
          state_d  = S_F1B;
        end
      end
      S_F1B: begin
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          t1_d     = mix;
          state_d  = S_F2A;
        end
      end
      S_F2A: begin
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          t2_d     = mix;
          state_d  = S_F2B;
        end
      end
      S_F2B: begin
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          t2_d     = mix;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = null_q ? 64'd0 : (t1_q + t2_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane1_q <= lane1_d;
    lane2_q <= lane2_d;
    total_q <= total_d;
    null_q  <= null_d;
    k1_q    <= k1_d;
    k2_q    <= k2_d;
    t1_q    <= t1_d;
    t2_q    <= t2_d;
    do_k2_q <= do_k2_d;
    full_q  <= full_d;
    last_q  <= last_d;
    out_q   <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/murmur3_x64_128_low64_hash_top.sv =====
// top level of the murmur3 x64_128 low-64 message hash block
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o data_low, data_high, byte_count,
//                                               last_block, seed, is_null
//   out      source     out_valid_o/out_stall_i hash_value
//
// the front takes one block per cycle into a two-entry queue while it is not full;
// the back works on one block at a time around a single shared 32x32 multiplier,
// a short tail taking fewer steps than a full block, and the last block also
// runs finalization
// rst_ni clears control state only; lanes and length reload on a first block
// in_stall_o is high only while the queue is full; a waiting result sits in
// the output register and the back holds its next result until it is taken
`timescale 1ns / 1ps
`default_nettype none

module murmur3_x64_128_low64_hash_top import m3h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_low_i,
  input  logic [63:0] data_high_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_block_i,
  input  logic [31:0] seed_i,
  input  logic        is_null_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  // front to queue
  logic       push;
  logic       q_full;
  blk_entry_t push_entry;

  // queue to back
  logic       q_valid;
  logic       q_pop;
  blk_entry_t q_entry;

  // back to shared multiplier
  mul_req_t   mul_req;
  mul_rsp_t   mul_rsp;

  // classify each item: effective count, masked tail, first/last marks
  m3h_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_low_i   (data_low_i),
    .data_high_i  (data_high_i),
    .byte_count_i (byte_count_i),
    .last_block_i (last_block_i),
    .seed_i       (seed_i),
    .is_null_i    (is_null_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // decouples item intake from the multiply-bound back end
  m3h_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // lane rounds, tail rule, length xor and finalizer
  m3h_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  // one 32x32 multiplier shared by all key and finalizer multiplies
  m3h_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/m3h_checker.sv =====
// port-level checker for the hash block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module m3h_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] hash_value_o
);

  // a result waiting under stall stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // and its value holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hash_value_o))
    else $error("result changed while stalled");

  // reset leaves no result behind
  a_rst_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered out of reset");

  // reset leaves the queue empty
  a_rst_in: assert property (@(posedge clk_i)
    !rst_ni |=> !in_stall_o)
    else $error("input stalled out of reset");

  // the queue only fills by taking an item
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted item");

endmodule

bind murmur3_x64_128_low64_hash_top m3h_checker u_m3h_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .hash_value_o (hash_value_o)
);

`default_nettype wire

// ===== tb/m3h_hash_checker.sv =====
// scoreboard for the murmur3 low-64 hash block: predicts each message hash and checks results
`timescale 1ns / 1ps

module m3h_hash_checker import m3h_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] data_low_i,
  input  logic [63:0] data_high_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_block_i,
  input  logic [31:0] seed_i,
  input  logic        is_null_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] hash_value_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [63:0]            lane_a;
  logic [63:0]            lane_b;
  logic [LENGTH_BITS-1:0] msg_len;
  logic                   in_message;
  logic                   null_flag;
  logic [63:0]            hash_expected_q[$];

  function automatic logic [63:0] rotl_word(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] key_mix_low(input logic [63:0] k);
    logic [63:0] x;
    x = k * MUL_A;
    x = rotl_word(x, 31);
    return x * MUL_B;
  endfunction

  function automatic logic [63:0] key_mix_high(input logic [63:0] k);
    logic [63:0] x;
    x = k * MUL_B;
    x = rotl_word(x, 33);
    return x * MUL_A;
  endfunction

  function automatic logic [63:0] avalanche(input logic [63:0] k);
    logic [63:0] x;
    x = k ^ (k >> 33);
    x = x * FIN_A;
    x = x ^ (x >> 33);
    x = x * FIN_B;
    return x ^ (x >> 33);
  endfunction

  // zero everything above the lowest n bytes
  function automatic logic [63:0] keep_bytes(input logic [63:0] v, input int unsigned n);
    if (n >= 8) return v;
    return v & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // fold one accepted block into the lanes, queue a hash on the last one
  task automatic absorb_block();
    int unsigned            cnt;
    logic [63:0]            s;
    logic [63:0]            h1;
    logic [63:0]            h2;
    logic [LENGTH_BITS-1:0] room;
    if (!in_message) begin
      s = {{32{seed_i[31]}}, seed_i};
      lane_a = s;
      lane_b = s;
      msg_len = '0;
      null_flag = 1'b0;
    end
    null_flag = null_flag | is_null_i;
    cnt = 32'(byte_count_i);
    if (cnt > 16 || !last_block_i) cnt = 16;
    if (cnt == 16) begin
      lane_a = lane_a ^ key_mix_low(data_low_i);
      lane_a = rotl_word(lane_a, 27) + lane_b;
      lane_a = lane_a * 64'd5 + ADD_ONE;
      lane_b = lane_b ^ key_mix_high(data_high_i);
      lane_b = rotl_word(lane_b, 31) + lane_a;
      lane_b = lane_b * 64'd5 + ADD_TWO;
    end else begin
      // tail: no lane rotate or add
      if (cnt > 8) lane_b = lane_b ^ key_mix_high(keep_bytes(data_high_i, cnt - 8));
      if (cnt > 0) lane_a = lane_a ^ key_mix_low(keep_bytes(data_low_i, cnt));
    end
    room = LEN_MAX - msg_len;
    if (64'(cnt) > 64'(room)) msg_len = LEN_MAX;
    else msg_len = msg_len + LENGTH_BITS'(cnt);
    if (last_block_i) begin
      h1 = lane_a ^ 64'(msg_len);
      h2 = lane_b ^ 64'(msg_len);
      h1 = h1 + h2;
      h2 = h2 + h1;
      h1 = avalanche(h1);
      h2 = avalanche(h2);
      h1 = h1 + h2;
      hash_expected_q.push_back(null_flag ? 64'd0 : h1);
      in_message = 1'b0;
    end else begin
      in_message = 1'b1;
    end
  endtask

  task automatic check_hash();
    logic [63:0] want;
    if (hash_expected_q.size() == 0) begin
      $display("%0t: unexpected hash: expected none, actual %016h", $time, hash_value_i);
      fail_count_o++;
    end else begin
      want = hash_expected_q.pop_front();
      if (hash_value_i !== want) begin
        $display("%0t: hash_value mismatch: expected %016h, actual %016h",
                 $time, want, hash_value_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_a = '0;
      lane_b = '0;
      msg_len = '0;
      in_message = 1'b0;
      null_flag = 1'b0;
      hash_expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_hash();
      if (in_valid_i && !in_stall_i) absorb_block();
      pending_o = hash_expected_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// top of the murmur3 low-64 hash regression: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import m3h_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] data_low_i;
  logic [63:0] data_high_i;
  logic [4:0]  byte_count_i;
  logic        last_block_i;
  logic [31:0] seed_i;
  logic        is_null_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] hash_value_o;

  int unsigned fail_count;
  int unsigned pending;

  // sender and receiver idle ceilings; zero gives a stretch with no idling
  int unsigned tx_max = 10;
  int unsigned rx_max = 10;
  int unsigned rx_hold = 0;
  int unsigned items_sent = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  murmur3_x64_128_low64_hash_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_low_i   (data_low_i),
    .data_high_i  (data_high_i),
    .byte_count_i (byte_count_i),
    .last_block_i (last_block_i),
    .seed_i       (seed_i),
    .is_null_i    (is_null_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  // checker watches both channels beside the block
  m3h_hash_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_low_i   (data_low_i),
    .data_high_i  (data_high_i),
    .byte_count_i (byte_count_i),
    .last_block_i (last_block_i),
    .seed_i       (seed_i),
    .is_null_i    (is_null_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_i (hash_value_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: after each taken hash, stall for a random hold of at most rx_max;
  // now and then switch to a stretch with no stall at all
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if ($urandom_range(0, 15) == 0) rx_max = (rx_max == 0) ? 10 : 0;
      rx_hold = $urandom_range(0, rx_max);
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (rx_hold != 0);
    if (rx_hold != 0) rx_hold--;
  end

  // one item on the input channel; entered and left just after a falling edge
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] cnt, input logic is_last,
                            input logic [31:0] seed, input logic nul);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_low_i   <= lo;
    data_high_i  <= hi;
    byte_count_i <= cnt;
    last_block_i <= is_last;
    seed_i       <= seed;
    is_null_i    <= nul;
    // hold the item until a rising edge sees no stall
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // hold off the sender until every queued hash has come out
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // random word, biased a little toward all zeros, all ones and sign bits
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0001;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int unsigned nblk;
    logic [4:0]  cnt;
    logic        is_last;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_low_i   = '0;
    data_high_i  = '0;
    byte_count_i = '0;
    last_block_i = 1'b0;
    seed_i       = '0;
    is_null_i    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty message, seed zero
    send_block(64'd0, 64'd0, 5'd0, 1'b1, 32'd0, 1'b0);
    // value-hash shape: single eight-byte last block, largest positive seed
    send_block('1, '1, 5'd8, 1'b1, 32'h7fff_ffff, 1'b0);
    // full last block gets the body round, most negative seed
    send_block('1, '1, 5'd16, 1'b1, 32'h8000_0000, 1'b0);
    // counts above sixteen clamp to sixteen
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd31, 1'b1, '1, 1'b0);
    send_block('1, 64'd0, 5'd17, 1'b1, 32'd1, 1'b0);
    // tails on both sides of the word split; bytes past the count must be ignored
    send_block('1, '1, 5'd1, 1'b1, 32'h1234_5678, 1'b0);
    send_block('1, '1, 5'd7, 1'b1, 32'h1234_5678, 1'b0);
    send_block('1, '1, 5'd9, 1'b1, 32'hdead_beef, 1'b0);
    send_block('1, '1, 5'd15, 1'b1, 32'hdead_beef, 1'b0);
    // short block that is not last is still a full block; seed on later item ignored
    send_block(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 5'd3, 1'b0, 32'd42, 1'b0);
    send_block(64'h9999_aaaa_bbbb_cccc, 64'hdddd_eeee_ffff_0000, 5'd12, 1'b0, '1, 1'b0);
    send_block('1, 64'd0, 5'd12, 1'b1, 32'h8000_0000, 1'b0);
    // empty last block after a full one
    send_block(64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0, 5'd16, 1'b0, 32'd7, 1'b0);
    send_block('1, '1, 5'd0, 1'b1, 32'd0, 1'b0);
    // null on a first item, then on a last item only
    send_block('1, '1, 5'd16, 1'b0, 32'd3, 1'b1);
    send_block('1, '1, 5'd5, 1'b1, 32'd3, 1'b0);
    send_block(64'h0bad_cafe_0bad_cafe, '1, 5'd10, 1'b1, 32'd9, 1'b1);
    // a plain message after the null one must hash normally again
    send_block(64'h0bad_cafe_0bad_cafe, '1, 5'd10, 1'b1, 32'd9, 1'b0);

    // pause the sender until the block has gone fully idle
    wait_for_results();

    // random messages: mostly one to three blocks, now and then long ones
    while (items_sent < 1050) begin
      if ($urandom_range(0, 9) == 0) tx_max = (tx_max == 0) ? 10 : 0;
      nblk = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      for (int b = 0; b < nblk; b++) begin
        is_last = (b == nblk - 1);
        if (is_last) begin
          cnt = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16));
        end else begin
          // non-last count is ignored by the block, so stray values are harmless noise
          cnt = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
        end
        send_block(rand_word(), rand_word(), cnt, is_last, $urandom,
                   ($urandom_range(0, 24) == 0));
      end
      if ($urandom_range(0, 39) == 0) wait_for_results();
    end

    // drain, then give the block time for any stray result
    wait_for_results();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, well above the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
